### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the CSV tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CSVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Signal holds its value in the cycle after a condition.
`define CSVT_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

### sv/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Types, byte codes and register indexes of the CSV record/field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

  localparam int MAX_FIELDS  = 256;
  localparam int RECORD_BITS = 32;
  localparam int FIELD_W     = $clog2(MAX_FIELDS);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [FIELD_W-1:0] FIELD_LAST = FIELD_W'(MAX_FIELDS - 1);

  // Special byte codes
  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] SEP_RESET  = 8'h2C;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLUMN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_QUOTES  = CFG_IDX_W'(4);

  // Select modes (code 3 behaves as SEL_CELL)
  localparam logic [1:0] SEL_ALL    = 2'd0;
  localparam logic [1:0] SEL_COLUMN = 2'd1;
  localparam logic [1:0] SEL_CELL   = 2'd2;

  typedef struct packed {
    logic [7:0]             separator;
    logic [1:0]             select_mode;
    logic [7:0]             target_column;
    logic [RECORD_BITS-1:0] target_row;
    logic                   strip_quotes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   is_data;
    logic [FIELD_W-1:0]     field_number;
    logic [RECORD_BITS-1:0] record_number;
    logic                   end_of_field;
    logic                   end_of_record;
    logic                   field_overflow;
  } result_t;

  // Handshake between the input register and the downstream stages
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } beat_t;

endpackage

`default_nettype wire

### sv/csvt_cfg.sv
// ----------------------------------------------------------------------------
// csvt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_cfg (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [csvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [csvt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output csvt_pkg::cfg_t                       cfg
);

  csvt_pkg::cfg_t cfg_r;

  // Register writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator     <= csvt_pkg::SEP_RESET;
      cfg_r.select_mode   <= csvt_pkg::SEL_ALL;
      cfg_r.target_column <= '0;
      cfg_r.target_row    <= '0;
      cfg_r.strip_quotes  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        csvt_pkg::REG_SEPARATOR:     cfg_r.separator     <= cfg_data[7:0];
        csvt_pkg::REG_SELECT_MODE:   cfg_r.select_mode   <= cfg_data[1:0];
        csvt_pkg::REG_TARGET_COLUMN: cfg_r.target_column <= cfg_data[7:0];
        csvt_pkg::REG_TARGET_ROW:
          cfg_r.target_row <= cfg_data[csvt_pkg::RECORD_BITS-1:0];
        csvt_pkg::REG_STRIP_QUOTES:  cfg_r.strip_quotes  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### sv/csvt_in_stage.sv
// ----------------------------------------------------------------------------
// csvt_in_stage
// Input register: holds one byte beat until the parse stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_in_stage (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       in_data_byte,
  input  wire              advance,
  output csvt_pkg::beat_t  beat
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       take;

  // Stall only while a held beat cannot move on
  assign in_stall = vld_r & ~advance;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data_byte;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule

`default_nettype wire

### sv/csvt_parse.sv
// ----------------------------------------------------------------------------
// csvt_parse
// Tokenizer state (quotes, CR-LF swallow, field/record counters) and the
// combinational classification of one byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_parse (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     advance,
  input  wire  [7:0]              data,
  input  csvt_pkg::cfg_t          cfg,
  output logic                    res_vld,
  output csvt_pkg::result_t       res
);

  logic                                inq_r, inq_nxt;
  logic                                swl_r, swl_nxt;
  logic [csvt_pkg::FIELD_W-1:0]        fld_r, fld_nxt;
  logic [csvt_pkg::RECORD_BITS-1:0]    rec_r, rec_nxt;
  logic                                ovf_r, ovf_nxt;

  logic is_quote, is_lf, is_cr, is_sep;
  logic col_hit, row_hit, pass;
  logic sat;

  // Byte classes, quote first, then LF, CR, separator
  assign is_quote = (data == csvt_pkg::QUOTE_BYTE);
  assign is_lf    = (data == csvt_pkg::LF_BYTE);
  assign is_cr    = (data == csvt_pkg::CR_BYTE);
  assign is_sep   = (data == cfg.separator) & ~is_quote & ~is_lf & ~is_cr;

  // Select filter
  assign col_hit = (fld_r == cfg.target_column);
  assign row_hit = (cfg.select_mode == csvt_pkg::SEL_ALL) ||
                   (cfg.select_mode == csvt_pkg::SEL_COLUMN) ||
                   (rec_r == cfg.target_row);
  assign pass    = (cfg.select_mode == csvt_pkg::SEL_ALL) | (col_hit & row_hit);
  assign sat     = (fld_r == csvt_pkg::FIELD_LAST);

  // Next state and result
  always_comb begin
    inq_nxt = inq_r;
    swl_nxt = 1'b0;
    fld_nxt = fld_r;
    rec_nxt = rec_r;
    ovf_nxt = ovf_r;

    res_vld            = 1'b0;
    res.out_byte       = 8'd0;
    res.is_data        = 1'b0;
    res.field_number   = fld_r;
    res.record_number  = rec_r;
    res.end_of_field   = 1'b0;
    res.end_of_record  = 1'b0;
    res.field_overflow = ovf_r;

    if (swl_r && is_lf) begin
      // LF of a CR-LF pair: dropped
    end else if (is_quote) begin
      inq_nxt = ~inq_r;
      if (!cfg.strip_quotes && pass) begin
        res_vld      = 1'b1;
        res.out_byte = data;
        res.is_data  = 1'b1;
      end
    end else if (is_lf || is_cr) begin
      if (!inq_r) begin
        res_vld           = row_hit;
        res.end_of_field  = 1'b1;
        res.end_of_record = 1'b1;
        fld_nxt           = '0;
        ovf_nxt           = 1'b0;
        rec_nxt           = rec_r + 1'b1;
        swl_nxt           = is_cr;
      end
    end else if (is_sep && !inq_r) begin
      res_vld          = pass;
      res.end_of_field = 1'b1;
      if (sat) begin
        ovf_nxt            = 1'b1;
        res.field_overflow = 1'b1;
      end else begin
        fld_nxt = fld_r + 1'b1;
      end
    end else begin
      res_vld      = pass;
      res.out_byte = data;
      res.is_data  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r <= 1'b0;
      swl_r <= 1'b0;
      fld_r <= '0;
      rec_r <= '0;
      ovf_r <= 1'b0;
    end else if (advance) begin
      inq_r <= inq_nxt;
      swl_r <= swl_nxt;
      fld_r <= fld_nxt;
      rec_r <= rec_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/csvt_out_stage.sv
// ----------------------------------------------------------------------------
// csvt_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_out_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  csvt_pkg::result_t   res,
  output logic                can_take,
  output logic                out_valid,
  input  wire                 out_stall,
  output csvt_pkg::result_t   out_res
);

  logic              vld_r, vld_nxt;
  csvt_pkg::result_t res_r;

  // Free when empty or emptied at this edge
  assign can_take = ~vld_r | ~out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### sv/csv_record_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_record_field_tokenizer_core
// Quote-aware CSV tokenizer: splits a byte stream into fields and records.
// ----------------------------------------------------------------------------
// One byte beat is accepted per cycle while in_stall is low, and yields zero
// or one result beat. A byte passes through an input register, is classified
// combinationally against the tokenizer state, and lands in the result
// register, from which out_valid is driven. Throughput is one byte per cycle
// while the result register is not held by out_stall; in_stall rises only
// when the result register is held by out_stall and the input register is
// full. Bytes that give no result (CR-LF second half, stripped quotes, line
// breaks inside quotes, filtered bytes) still pass through the input
// register. Configuration must be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_record_field_tokenizer_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration
  input  wire                                  cfg_we,
  input  wire  [csvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [csvt_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Byte input
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [7:0]                           in_data_byte,
  // Result output
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_is_data,
  output logic [csvt_pkg::FIELD_W-1:0]         out_field_number,
  output logic [csvt_pkg::RECORD_BITS-1:0]     out_record_number,
  output logic                                 out_end_of_field,
  output logic                                 out_end_of_record,
  output logic                                 out_field_overflow
);

  csvt_pkg::cfg_t    cfg;
  csvt_pkg::beat_t   beat;
  csvt_pkg::result_t res;
  csvt_pkg::result_t out_res;
  logic              res_vld;
  logic              can_take;
  logic              advance;

  // A held byte moves on whenever the result register is free
  assign advance = beat.vld & can_take;

  csvt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csvt_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .advance      (advance),
    .beat         (beat)
  );

  csvt_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .data    (beat.data),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  csvt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance & res_vld),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte           = out_res.out_byte;
  assign out_is_data        = out_res.is_data;
  assign out_field_number   = out_res.field_number;
  assign out_record_number  = out_res.record_number;
  assign out_end_of_field   = out_res.end_of_field;
  assign out_end_of_record  = out_res.end_of_record;
  assign out_field_overflow = out_res.field_overflow;

endmodule

`default_nettype wire

### sv/csvt_checker.sv
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks of the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module csvt_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  out_valid,
  input wire                                  out_stall,
  input wire  [7:0]                           out_byte,
  input wire                                  out_is_data,
  input wire  [csvt_pkg::FIELD_W-1:0]         out_field_number,
  input wire  [csvt_pkg::RECORD_BITS-1:0]     out_record_number,
  input wire                                  out_end_of_field,
  input wire                                  out_end_of_record
);

  // Stalled result beat keeps its record index
  `CSVT_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid && out_stall, out_record_number, "stalled result changed")

  // Marker beats always close a field and carry a zero byte
  `CSVT_ASSERT(a_marker_form, clk, rst_n, (out_valid && !out_is_data) |-> (out_end_of_field && out_byte == 8'd0), "malformed marker")

  // Data beats carry no end flags
  `CSVT_ASSERT(a_data_form, clk, rst_n, (out_valid && out_is_data) |-> (!out_end_of_field && !out_end_of_record), "data beat with end flag")

  // After a record end is taken, later beats start at field zero in a new record
  `CSVT_ASSERT(a_record_next, clk, rst_n, (out_valid && !out_stall && out_end_of_record) |=> (!out_valid || (out_record_number != $past(out_record_number) && out_field_number == '0)), "record end not followed by new record")

endmodule

bind csv_record_field_tokenizer_core csvt_checker u_csvt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_is_data       (out_is_data),
  .out_field_number  (out_field_number),
  .out_record_number (out_record_number),
  .out_end_of_field  (out_end_of_field),
  .out_end_of_record (out_end_of_record)
);

`default_nettype wire
